// ----- hdl/bit_matrix_tag_table_core_assert.svh -----
// Assertion macros for the bit matrix tag table core.
// Expects clk and arst_n in the scope of each use.
`ifndef BIT_MATRIX_TAG_TABLE_CORE_ASSERT_SVH
`define BIT_MATRIX_TAG_TABLE_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset only.
`define BMTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset only.
`define BMTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BMTT_ASSERT_IMP(lbl, ante, cons, msg)
`define BMTT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/bmtt_pkg.sv -----
// Shared types, codes and helpers of the bit matrix tag table core.
// No dependencies; all other files but bmtt_ram and the assertion header use it.
package bmtt_pkg;

	localparam int CMD_W      = 3;
	localparam int ROW_W      = 8;
	localparam int OFF_W      = 5;
	localparam int BYTE_W     = 8;
	localparam int COL_W      = 8;
	localparam int CNT_W      = 9;
	localparam int ROWCNT_W   = 9;
	localparam int COLCNT_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int RB_W       = 6;

	localparam logic [CMD_W-1:0] CMD_OR_BITS   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COUNT_ROW = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COUNT_COL = 3'd4;

	localparam logic [BYTE_W-1:0] BIT_MSB_MASK = 8'h80;
	localparam logic [CNT_W-1:0]  COUNT_MAX    = 9'h1FF;
	localparam logic [1:0]        PAIR_BITS [4] = '{2'd0, 2'd1, 2'd1, 2'd2};

	localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST    = 9'd256;
	localparam logic [COLCNT_W-1:0] COLUMN_COUNT_RST = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT    = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RMW,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic clr_step;
		logic load;
		logic exec_write;
		logic rmw;
		logic walk_issue;
		logic load_out;
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clr_done;
		logic item_ok;
		logic is_write;
		logic is_rmw;
		logic walk_empty;
		logic walk_last;
	} dp_stat_t;

	// Population count of one byte, two bits at a time.
	function automatic logic [3:0] byte_pop(input logic [7:0] v);
		return 4'(PAIR_BITS[v[1:0]]) + 4'(PAIR_BITS[v[3:2]]) +
		       4'(PAIR_BITS[v[5:4]]) + 4'(PAIR_BITS[v[7:6]]);
	endfunction

endpackage

// ----- hdl/bmtt_req_if.sv -----
// Request channel of the bit matrix tag table core: one command word.
// Depends on bmtt_pkg for field widths.
interface bmtt_req_if;
	logic                         valid;
	logic                         ready;
	logic [bmtt_pkg::CMD_W-1:0]   cmd;
	logic [bmtt_pkg::ROW_W-1:0]   row;
	logic [bmtt_pkg::OFF_W-1:0]   byte_index;
	logic [bmtt_pkg::BYTE_W-1:0]  byte_value;
	logic [bmtt_pkg::COL_W-1:0]   column;

	modport source (output valid, cmd, row, byte_index, byte_value, column, input ready);
	modport sink (input valid, cmd, row, byte_index, byte_value, column, output ready);
endinterface

// ----- hdl/bmtt_rsp_if.sv -----
// Response channel of the bit matrix tag table core: one result word.
// Depends on bmtt_pkg for field widths.
interface bmtt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         status;
	logic [bmtt_pkg::BYTE_W-1:0]  read_byte;
	logic [bmtt_pkg::CNT_W-1:0]   bit_count;

	modport source (output valid, status, read_byte, bit_count, input ready);
	modport sink (input valid, status, read_byte, bit_count, output ready);
endinterface

// ----- hdl/bmtt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bmtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- hdl/bmtt_ctrl.sv -----
// Controller of the bit matrix tag table core: sequences clear, byte ops and walks.
// Depends on bmtt_pkg for state, command and status types.
module bmtt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  bmtt_pkg::dp_stat_t  stat,
	output bmtt_pkg::ctl_cmd_t  cmd
);
	import bmtt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!stat.item_ok || stat.is_write) state_d = ST_FINISH;
				else if (stat.is_rmw) state_d = ST_RMW;
				else if (stat.walk_empty) state_d = ST_FINISH;
				else state_d = ST_WALK;
			end
			ST_RMW: state_d = ST_FINISH;
			ST_WALK: begin
				if (stat.walk_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_EXEC: begin
				cmd.exec_write = stat.item_ok && stat.is_write;
			end
			ST_RMW: cmd.rmw = 1'b1;
			ST_WALK: cmd.walk_issue = 1'b1;
			ST_DRAIN: ;
			ST_FINISH: cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
endmodule

// ----- hdl/bmtt_dp.sv -----
// Datapath of the bit matrix tag table core: config registers, item registers,
// table RAM, walk counter and saturating bit accumulator. Uses bmtt_pkg, bmtt_ram.
module bmtt_dp #(
	parameter int MAX_ROWS      = 256,
	parameter int MAX_ROW_BYTES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bmtt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmtt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [bmtt_pkg::CMD_W-1:0]       in_cmd,
	input  logic [bmtt_pkg::ROW_W-1:0]       in_row,
	input  logic [bmtt_pkg::OFF_W-1:0]       in_byte_index,
	input  logic [bmtt_pkg::BYTE_W-1:0]      in_byte_value,
	input  logic [bmtt_pkg::COL_W-1:0]       in_column,
	input  bmtt_pkg::ctl_cmd_t               cmd,
	output bmtt_pkg::dp_stat_t               stat,
	output logic                             out_status,
	output logic [bmtt_pkg::BYTE_W-1:0]      out_read_byte,
	output logic [bmtt_pkg::CNT_W-1:0]       out_bit_count
);
	import bmtt_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_ROW_BYTES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [ROWCNT_W-1:0] row_count_q;
	logic [COLCNT_W-1:0] column_count_q;

	logic [CMD_W-1:0]    cmd_q;
	logic [ROW_W-1:0]    row_q;
	logic [OFF_W-1:0]    off_q;
	logic [BYTE_W-1:0]   val_q;
	logic [COL_W-1:0]    col_q;
	logic                ok_q;
	logic [ROWCNT_W-1:0] idx_q;
	logic [CNT_W-1:0]    acc_q;
	logic [BYTE_W-1:0]   rd_q;
	logic                acc_en_s1;
	logic [AW-1:0]       clr_q;

	logic                o_status_q;
	logic [BYTE_W-1:0]   o_read_q;
	logic [CNT_W-1:0]    o_count_q;

	logic [ROWCNT_W-1:0] rows_w;
	logic [RB_W-1:0]     rb_n;
	logic [RB_W-1:0]     rb_w;
	logic                in_ok;
	logic                count_row;
	logic [ROWCNT_W-1:0] walk_n;
	logic [AW-1:0]       byte_addr;
	logic [AW-1:0]       walk_addr;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [BYTE_W-1:0]   mem_wdata;
	logic [AW-1:0]       mem_raddr;
	logic [BYTE_W-1:0]   mem_rdata;
	logic [3:0]          contrib;
	logic [CNT_W:0]      acc_sum;

	// Row r starts at a fixed stride of MAX_ROW_BYTES.
	function automatic logic [AW-1:0] addr_of(input logic [ROWCNT_W-1:0] r,
	                                          input logic [RB_W-1:0] o);
		return AW'(32'(r) * 32'(MAX_ROW_BYTES) + 32'(o));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= ROW_COUNT_RST;
			column_count_q <= COLUMN_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT:    row_count_q    <= cfg_data[ROWCNT_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= cfg_data[COLCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp rows in use and row length to capacity.
	assign rows_w = (32'(row_count_q) > 32'(MAX_ROWS)) ? ROWCNT_W'(MAX_ROWS) : row_count_q;
	assign rb_n   = RB_W'(column_count_q[COLCNT_W-1:3]) + RB_W'(1);
	assign rb_w   = (32'(rb_n) > 32'(MAX_ROW_BYTES)) ? RB_W'(MAX_ROW_BYTES) : rb_n;

	always_comb begin
		unique case (in_cmd) inside
			CMD_OR_BITS, CMD_WRITE, CMD_READ:
				in_ok = ({1'b0, in_row} < rows_w) && ({1'b0, in_byte_index} < rb_w);
			CMD_COUNT_ROW:
				in_ok = {1'b0, in_row} < rows_w;
			CMD_COUNT_COL:
				in_ok = (in_column < column_count_q) &&
				        ({1'b0, in_column[COL_W-1:3]} < rb_w);
			default: in_ok = 1'b0;
		endcase
	end

	assign count_row = (cmd_q == CMD_COUNT_ROW);
	assign walk_n    = count_row ? ROWCNT_W'(rb_w) : rows_w;
	assign byte_addr = addr_of(ROWCNT_W'(row_q), RB_W'(off_q));
	assign walk_addr = count_row ? addr_of(ROWCNT_W'(row_q), RB_W'(idx_q))
	                             : addr_of(idx_q, RB_W'(col_q[COL_W-1:3]));

	assign mem_we    = cmd.clr_step || cmd.exec_write || (cmd.rmw && cmd_q == CMD_OR_BITS);
	assign mem_waddr = cmd.clr_step ? clr_q : byte_addr;
	assign mem_wdata = cmd.clr_step ? '0 :
	                   (cmd_q == CMD_OR_BITS) ? (mem_rdata | val_q) : val_q;
	assign mem_raddr = cmd.walk_issue ? walk_addr : byte_addr;

	bmtt_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign contrib = count_row ? byte_pop(mem_rdata)
	                           : 4'(|(mem_rdata & (BIT_MSB_MASK >> col_q[2:0])));
	assign acc_sum = {1'b0, acc_q} + (CNT_W+1)'(contrib);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			acc_en_s1 <= 1'b0;
			idx_q     <= '0;
			ok_q      <= 1'b0;
			cmd_q     <= CMD_OR_BITS;
		end else begin
			acc_en_s1 <= cmd.walk_issue;
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.load) begin
				cmd_q <= in_cmd;
				ok_q  <= in_ok;
				idx_q <= '0;
			end else if (cmd.walk_issue) begin
				idx_q <= idx_q + ROWCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q <= in_row;
			off_q <= in_byte_index;
			val_q <= in_byte_value;
			col_q <= in_column;
			acc_q <= '0;
			rd_q  <= '0;
		end else begin
			if (acc_en_s1) acc_q <= acc_sum[CNT_W] ? COUNT_MAX : acc_sum[CNT_W-1:0];
			if (cmd.rmw && cmd_q == CMD_READ) rd_q <= mem_rdata;
		end
		if (cmd.load_out) begin
			o_status_q <= !ok_q;
			o_read_q   <= rd_q;
			o_count_q  <= acc_q;
		end
	end

	assign stat.clr_done   = (clr_q == AW'(DEPTH - 1));
	assign stat.item_ok    = ok_q;
	assign stat.is_write   = (cmd_q == CMD_WRITE);
	assign stat.is_rmw     = (cmd_q == CMD_OR_BITS) || (cmd_q == CMD_READ);
	assign stat.walk_empty = (walk_n == '0);
	assign stat.walk_last  = (idx_q == walk_n - ROWCNT_W'(1));

	assign out_status    = o_status_q;
	assign out_read_byte = o_read_q;
	assign out_bit_count = o_count_q;
endmodule

// ----- hdl/bit_matrix_tag_table_core.sv -----
// Channel   Dir  Word fields                                   Accepted when
// req       in   cmd, row, byte_index, byte_value, column      req.valid && req.ready
// rsp       out  status, read_byte, bit_count                  rsp.valid && rsp.ready
// cfg       in   cfg_index, cfg_data                           cfg_we
//
// Top level of the bit matrix tag table core: byte-organized bit matrix with
// row and column population counts. Uses bmtt_pkg, bmtt_ctrl, bmtt_dp, interfaces.
//
// Per word: a write stores its byte; OR and read first read the byte (OR then
//   writes the merged byte back); a row count walks row_bytes bytes and a column
//   count walks rows_in_use bytes, one byte per cycle through the single read port
//   of the table RAM. An invalid word or a column count with no rows in use skips it.
// Reset: a clearing pass writes zero to all MAX_ROWS*MAX_ROW_BYTES entries (8192
//   at default size), one per cycle; req.ready stays low, cfg writes land.
// Stalls: a finished result waits in the output register while the next word is
//   accepted; that word's result holds in the controller until the register frees.
module bit_matrix_tag_table_core #(
	parameter int MAX_ROWS      = 256,
	parameter int MAX_ROW_BYTES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bmtt_req_if.sink                         req,
	bmtt_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [bmtt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmtt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bmtt_pkg::*;

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	// Sequence the clearing pass, then each word: capture, byte access or walk, hand off.
	bmtt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (dp_stat),
		.cmd       (ctl_cmd)
	);

	// Hold config, table, counters and the output register.
	bmtt_dp #(
		.MAX_ROWS      (MAX_ROWS),
		.MAX_ROW_BYTES (MAX_ROW_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_cmd         (req.cmd),
		.in_row         (req.row),
		.in_byte_index  (req.byte_index),
		.in_byte_value  (req.byte_value),
		.in_column      (req.column),
		.cmd            (ctl_cmd),
		.stat           (dp_stat),
		.out_status     (rsp.status),
		.out_read_byte  (rsp.read_byte),
		.out_bit_count  (rsp.bit_count)
	);

	`include "bit_matrix_tag_table_core_assert.svh"

	// One word in flight: drop ready right after an accept.
	`BMTT_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready, "word accepted while busy")
	// Load the output register only when it is free or draining.
	`BMTT_ASSERT_IMP(a_load_out_free, ctl_cmd.load_out, !rsp.valid || rsp.ready, "result overrun")
	// Accept nothing during the clearing pass.
	`BMTT_ASSERT_IMP(a_clear_blocks, ctl_cmd.clr_step, !req.ready, "accept during clear")
	// Stop walking after the last index.
	`BMTT_ASSERT_NXT(a_walk_stops, ctl_cmd.walk_issue && dp_stat.walk_last, !ctl_cmd.walk_issue,
		"walk overran its length")
endmodule
